### hw/rtl/i2a_pkg.sv
// Shared types, codes and character constants for the integer to ASCII formatter.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int BCD_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int DCNT_W     = 4;
    localparam int BCNT_W     = 6;

    localparam logic [1:0] KIND_SIGNED = 2'd1;
    localparam logic [1:0] KIND_HEX    = 2'd2;

    localparam logic [1:0] PRE_NONE  = 2'd0;
    localparam logic [1:0] PRE_MINUS = 2'd1;
    localparam logic [1:0] PRE_HEX   = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic hex;
        logic neg;
    } emit_cmd_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CONV,
        T_HEX,
        T_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_PREFIX,
        E_DIGITS,
        E_SPACE
    } emit_state_t;

endpackage

### hw/rtl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: control FSM, BCD converter, sequencer.
// Depends on i2a_pkg, i2a_dabble and i2a_emit.
`timescale 1ns / 1ps

// Usage:
//   s_valid/s_ready/s_data carry one item: kind (0 unsigned decimal, 1 signed
//   decimal, 2 hex with "0x") and a 32-bit value. m_valid/m_ready/m_data return
//   the characters, most significant first, ending with a space marked last.
//   One item is worked on at a time; s_ready is high only while the block is idle.
//   Decimal kinds: the item is accepted, the bit-serial BCD converter runs, the
//   sequencer is started and steps over all ten digit positions (a leading zero
//   is dropped without output), then the space is sent and the block returns to
//   idle; a negative signed item sends a minus sign ahead of the digits.
//   Nonzero hex items skip the converter: the item is accepted, the sequencer is started,
//   then come the two prefix characters, eight nibble positions (leading zeros are
//   dropped too), the space and the return to idle. A stalled receiver holds the
//   output register and the sequencer waits with it; s_ready rises once the control
//   FSM has seen the sequencer go idle, after the final space enters the output register.
//   Reset clears the control state and the output valid; no item is pending.

module integer_to_ascii_formatter
    import i2a_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    top_state_t         state_reg, state_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic               hex_reg, hex_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] mag_in;
    logic               accept;
    logic               in_hex;
    logic               in_neg;
    logic               dab_start;
    logic               dab_done;
    logic [BCD_W-1:0]   dab_bcd;
    logic [BCD_W-1:0]   emit_digits;
    emit_cmd_t          emit_cmd;
    logic               emit_busy;

    assign accept = s_valid && s_ready;
    // zero in hex mode prints like decimal zero, without the prefix
    assign in_hex = (s_data.kind == KIND_HEX) && (s_data.value != '0);
    assign in_neg = (s_data.kind == KIND_SIGNED) && s_data.value[VALUE_W-1];
    assign mag_in = in_neg ? (~s_data.value + 1'b1) : s_data.value;

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        hex_next       = hex_reg;
        neg_next       = neg_reg;
        dab_start      = 1'b0;
        emit_cmd.start = 1'b0;
        emit_cmd.hex   = hex_reg;
        emit_cmd.neg   = neg_reg;
        emit_digits    = dab_bcd;
        case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    mag_next   = mag_in;
                    hex_next   = in_hex;
                    neg_next   = in_neg;
                    dab_start  = !in_hex;
                    state_next = in_hex ? T_HEX : T_CONV;
                end
            end
            T_CONV: begin
                if (dab_done) begin
                    emit_cmd.start = 1'b1;
                    state_next     = T_EMIT;
                end
            end
            T_HEX: begin
                emit_cmd.start = 1'b1;
                emit_digits    = {mag_reg, {(BCD_W-VALUE_W){1'b0}}};
                state_next     = T_EMIT;
            end
            T_EMIT: begin
                if (!emit_busy) begin
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg <= mag_next;
        hex_reg <= hex_next;
        neg_reg <= neg_next;
    end

    assign s_ready = (state_reg == T_IDLE);

    i2a_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dab_start),
        .mag     (mag_in),
        .done    (dab_done),
        .bcd     (dab_bcd)
    );

    i2a_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (emit_cmd),
        .digits  (emit_digits),
        .busy    (emit_busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_idle_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_IDLE) |-> !emit_busy)
        else $error("sequencer busy while the block is idle");

    a_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        dab_done |-> (state_reg == T_CONV))
        else $error("converter finished outside the conversion state");

    a_last_is_space: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last) |-> (m_data.out_char == CH_SPACE))
        else $error("last item is not the trailing space");

endmodule

### hw/rtl/i2a_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), one input bit per cycle.
// Depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_dabble
    import i2a_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] mag,
    output logic               done,
    output logic [BCD_W-1:0]   bcd
);

    logic [VALUE_W-1:0] sh_reg, sh_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   adj;
    logic [BCNT_W-1:0]  cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    // Each digit is corrected on its own before the shift.
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        sh_next   = sh_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            sh_next  = mag;
            bcd_next = '0;
            cnt_next = BCNT_W'(VALUE_W);
            run_next = 1'b1;
        end else if (run_reg) begin
            bcd_next = {adj[BCD_W-2:0], sh_reg[VALUE_W-1]};
            sh_next  = {sh_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == BCNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

### hw/rtl/i2a_emit.sv
// Character sequencer: prefix, digits without leading zeros, trailing space.
// Shifts one digit per cycle into the output register unless stalled. Uses i2a_pkg.
`timescale 1ns / 1ps

module i2a_emit
    import i2a_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  emit_cmd_t        cmd,
    input  logic [BCD_W-1:0] digits,
    output logic             busy,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    emit_state_t       state_reg, state_next;
    logic [BCD_W-1:0]  dig_reg, dig_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        pre_reg, pre_next;
    logic              hex_reg, hex_next;
    logic              lead_reg, lead_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;
    logic              can_load;
    logic [3:0]        dig_top;

    assign can_load = !m_valid_reg || m_ready;
    assign dig_top  = dig_reg[BCD_W-1 -: 4];

    always_comb begin
        state_next   = state_reg;
        dig_next     = dig_reg;
        cnt_next     = cnt_reg;
        pre_next     = pre_reg;
        hex_next     = hex_reg;
        lead_next    = lead_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            E_IDLE: begin
                if (cmd.start) begin
                    hex_next  = cmd.hex;
                    lead_next = 1'b1;
                    if (cmd.hex) begin
                        dig_next = digits;
                        cnt_next = DCNT_W'(HEX_DIGITS);
                        pre_next = PRE_HEX;
                    end else begin
                        dig_next = digits;
                        cnt_next = DCNT_W'(BCD_DIGITS);
                        pre_next = cmd.neg ? PRE_MINUS : PRE_NONE;
                    end
                    state_next = (cmd.hex || cmd.neg) ? E_PREFIX : E_DIGITS;
                end
            end
            E_PREFIX: begin
                if (can_load) begin
                    m_valid_next     = 1'b1;
                    m_data_next.last = 1'b0;
                    if (hex_reg) begin
                        m_data_next.out_char = (pre_reg == PRE_HEX) ? CH_ZERO : CH_X;
                    end else begin
                        m_data_next.out_char = CH_MINUS;
                    end
                    pre_next = pre_reg - 1'b1;
                    if (pre_reg == PRE_MINUS) begin
                        state_next = E_DIGITS;
                    end
                end
            end
            E_DIGITS: begin
                if (lead_reg && dig_top == 4'd0 && cnt_reg != DCNT_W'(1)) begin
                    // drop a leading zero; the last digit always prints
                    dig_next = {dig_reg[BCD_W-5:0], 4'h0};
                    cnt_next = cnt_reg - 1'b1;
                end else if (can_load) begin
                    m_valid_next         = 1'b1;
                    m_data_next.out_char = DIGIT_CHARS[dig_top];
                    m_data_next.last     = 1'b0;
                    dig_next             = {dig_reg[BCD_W-5:0], 4'h0};
                    cnt_next             = cnt_reg - 1'b1;
                    lead_next            = 1'b0;
                    if (cnt_reg == DCNT_W'(1)) begin
                        state_next = E_SPACE;
                    end
                end
            end
            E_SPACE: begin
                if (can_load) begin
                    m_valid_next         = 1'b1;
                    m_data_next.out_char = CH_SPACE;
                    m_data_next.last     = 1'b1;
                    state_next           = E_IDLE;
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        dig_reg    <= dig_next;
        cnt_reg    <= cnt_next;
        pre_reg    <= pre_next;
        hex_reg    <= hex_next;
        lead_reg   <= lead_next;
        m_data_reg <= m_data_next;
    end

    assign busy    = (state_reg != E_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### bench/integer_to_ascii_formatter_tb.sv
// Self-checking bench for integer_to_ascii_formatter: a directed table, then random items.
// Depends on i2a_pkg and the formatter RTL; every emitted character is checked in order.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;
    import i2a_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 6;
    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 460;
    localparam int DRAIN_CYCLES  = 60;
    localparam int STALL_LIMIT   = 2000;

    // The package names only the signed and hex kinds; the other two decode as unsigned.
    localparam logic [1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [1:0] KIND_SPARE    = 2'd3;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    out_item_t expected_chars [$];
    int        failures      = 0;
    int        chars_checked = 0;
    int        kind_count [4] = '{0, 0, 0, 0};
    int        burst_left    = 0;

    rx_mode_t  rx_mode       = RX_OPEN;
    int        rx_mode_left  = 0;
    int        rx_phase      = 0;

    integer_to_ascii_formatter u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void expect_char(input logic [7:0] ch, input logic is_last);
        expected_chars.push_back('{out_char: ch, last: is_last});
    endfunction

    function automatic void expect_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            expect_char(txt[i], i == txt.len() - 1);
        end
    endfunction

    // Build the characters of one number, least significant digit first, then emit reversed.
    function automatic void format_number(input in_item_t it);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [31:0] nib;
        logic [7:0]  digits [$];
        mag   = it.value;
        radix = 32'd10;
        if (it.value == 32'd0) begin
            expect_char(CH_ZERO, 1'b0);
            expect_char(CH_SPACE, 1'b1);
            return;
        end
        if (it.kind == KIND_HEX) begin
            radix = 32'd16;
            expect_char(CH_ZERO, 1'b0);
            expect_char(CH_X, 1'b0);
        end else if (it.kind == KIND_SIGNED && it.value[31]) begin
            mag = 32'd0 - it.value;
            expect_char(CH_MINUS, 1'b0);
        end
        while (mag != 32'd0) begin
            nib = mag % radix;
            if (nib < 10) digits.push_front(CH_ZERO + nib[7:0]);
            else          digits.push_front(CH_UPPER_A + nib[7:0] - 8'd10);
            mag = mag / radix;
        end
        foreach (digits[i]) expect_char(digits[i], 1'b0);
        expect_char(CH_SPACE, 1'b1);
    endfunction

    // Expected text is typed in only where it is obvious; an empty string means predict.
    function automatic void directed_row(input int row, output in_item_t it,
                                         output string txt);
        logic [1:0]  k;
        logic [31:0] v;
        txt = "";
        k   = KIND_UNSIGNED;
        v   = 32'd0;
        case (row)
            0:  begin k = KIND_UNSIGNED; v = 32'h0000_0000; txt = "0 ";            end
            1:  begin k = KIND_SIGNED;   v = 32'h0000_0000; txt = "0 ";            end
            2:  begin k = KIND_HEX;      v = 32'h0000_0000; txt = "0 ";            end
            3:  begin k = KIND_SPARE;    v = 32'h0000_0000; txt = "0 ";            end
            4:  begin k = KIND_UNSIGNED; v = 32'hFFFF_FFFF; txt = "4294967295 ";   end
            5:  begin k = KIND_SIGNED;   v = 32'hFFFF_FFFF; txt = "-1 ";           end
            6:  begin k = KIND_HEX;      v = 32'hFFFF_FFFF; txt = "0xFFFFFFFF ";   end
            7:  begin k = KIND_SIGNED;   v = 32'h8000_0000; txt = "-2147483648 ";  end
            8:  begin k = KIND_SIGNED;   v = 32'h7FFF_FFFF; txt = "2147483647 ";   end
            9:  begin k = KIND_UNSIGNED; v = 32'h8000_0000; txt = "2147483648 ";   end
            10: begin k = KIND_HEX;      v = 32'h8000_0000; txt = "0x80000000 ";   end
            11: begin k = KIND_UNSIGNED; v = 32'h0000_0001; txt = "1 ";            end
            12: begin k = KIND_HEX;      v = 32'h0000_0001; txt = "0x1 ";          end
            13: begin k = KIND_SIGNED;   v = 32'h0000_0001; txt = "1 ";            end
            14: begin k = KIND_SPARE;    v = 32'hFFFF_FFFF; txt = "4294967295 ";   end
            15: begin k = KIND_UNSIGNED; v = 32'd1000000000;                       end
            16: begin k = KIND_UNSIGNED; v = 32'd999999999;                        end
            17: begin k = KIND_HEX;      v = 32'hABCD_EF01;                        end
            18: begin k = KIND_SIGNED;   v = 32'hFFFF_FFF6; txt = "-10 ";          end
            19: begin k = KIND_HEX;      v = 32'h0000_0010;                        end
            20: begin k = KIND_SIGNED;   v = 32'h8000_0001;                        end
            21: begin k = KIND_SPARE;    v = 32'd12345;                            end
            22: begin k = KIND_UNSIGNED; v = 32'd9;                                end
            default: begin k = KIND_HEX; v = 32'h0000_000F;                        end
        endcase
        it = '{kind: k, value: v};
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] p;
        p = 32'd1;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 99);
            2: return $urandom >> $urandom_range(0, 31);
            3: begin
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                return p + $urandom_range(0, 2) - 32'd1;
            end
            4: begin
                if ($urandom_range(0, 1) == 0) return 32'h7FFF_FFFE + $urandom_range(0, 3);
                return 32'hFFFF_FFFF - $urandom_range(0, 3);
            end
            default: return 32'($urandom_range(1, 15)) << ($urandom_range(0, 7) * 4);
        endcase
    endfunction

    // Send in bursts; between bursts drop valid for a random gap, sometimes none.
    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        kind_count[it.kind]++;
    endtask

    initial begin : stimulus
        in_item_t it;
        string    txt;
        int       r;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            directed_row(row, it, txt);
            send_item(it);
            if (txt.len() != 0) expect_text(txt);
            else                format_number(it);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 19);
            it.kind  = (r == 0) ? KIND_SPARE : 2'(r % 3);
            it.value = random_value();
            send_item(it);
            format_number(it);
        end
        s_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Formatted %0d numbers: %0d unsigned, %0d signed, %0d hex, %0d spare kind.",
                 kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        $display("Compared %0d characters under a receiver that stalls in four patterns.",
                 chars_checked);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Receiver: hold one stall pattern for a while, then draw a pattern again at random.
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(50, 400);
        end
        rx_mode_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= ((rx_phase % 7) >= 4);
        endcase
    end

    always @(posedge aclk) begin : char_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                $error("unexpected character 0x%02h last=%0b", m_data.out_char, m_data.last);
                failures++;
            end else begin
                want = expected_chars.pop_front();
                if (m_data.out_char !== want.out_char) begin
                    $error("out_char: expected 0x%02h, got 0x%02h",
                           want.out_char, m_data.out_char);
                    failures++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_data.last);
                    failures++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else                                              idle_cycles++;
        end
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_dabble.sv
hw/rtl/i2a_emit.sv
hw/rtl/integer_to_ascii_formatter.sv
bench/integer_to_ascii_formatter_tb.sv
